FILE: rtl/cge_pkg.sv
`timescale 1ns / 1ps

package cge_pkg;

  // default sizing
  localparam int unsigned MAX_STOPS_DEF   = 16;
  localparam int unsigned RAMP_LENGTH_DEF = 256;

  // fixed field widths
  localparam int unsigned OP_W        = 1;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned POS_W       = 9;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned STOP_CNT_W  = 5;
  localparam int unsigned NUM_CH      = 4;

  // blend numerator and divider sizing
  localparam int unsigned NUM_W       = 17;
  localparam int unsigned DIV_STEPS   = 8;
  localparam int unsigned DIV_CNT_W   = 3;

  // channel lanes
  localparam int unsigned CH_RED      = 0;
  localparam int unsigned CH_GREEN    = 1;
  localparam int unsigned CH_BLUE     = 2;
  localparam int unsigned CH_ALPHA    = 3;

  localparam logic [STOP_CNT_W-1:0] STOP_CNT_RST = STOP_CNT_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } cge_op_e;

  typedef struct packed {
    cge_op_e               operation;
    logic [IDX_W-1:0]      stop_index;
    logic [POS_W-1:0]      stop_position;
    logic [CH_W-1:0]       stop_red;
    logic [CH_W-1:0]       stop_green;
    logic [CH_W-1:0]       stop_blue;
    logic [CH_W-1:0]       stop_alpha;
    logic [SAMPLE_W-1:0]   sample_position;
  } cge_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
    logic            covered;
  } cge_result_t;

  // one color stop as held in the table
  typedef struct packed {
    logic [POS_W-1:0]             pos;
    logic [NUM_CH-1:0][CH_W-1:0]  ch;
  } cge_stop_t;

  localparam cge_stop_t STOP_ZERO  = '{pos: '0, ch: '0};
  localparam cge_stop_t STOP_WHITE = '{pos: POS_W'(256), ch: '1};

  // controller to datapath
  typedef struct packed {
    logic wr_stop;
    logic capture;
    logic rd_en;
    logic calc;
    logic div_step;
  } cge_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;
    logic scan_last;
  } cge_status_t;

endpackage

FILE: rtl/color_gradient_evaluator_core.sv
`timescale 1ns / 1ps

// Piecewise linear color gradient over a table of up to MAX_STOPS color stops.
// An item is taken when start_i is high and busy_o is low. A stop write takes
// effect at that edge and busy_o stays low, so writes may follow every cycle.
// An evaluate raises busy_o and scans n stops, n being stop_count clamped to
// MAX_STOPS: the table has one read port and is scanned one stop per cycle,
// then the four channels go through an 8-step restoring divider in parallel.
// When the sample lies at or beyond RAMP_LENGTH or n is below two, scan and
// divide are skipped. The result shows on result_o for exactly the one
// cycle in which result_strobe_o is high, the last busy cycle; there is no
// back-pressure, so the receiver must take it then. The next item can be
// accepted in the following cycle. cfg_ready_o is always high and stop_count
// is meant to be written only while busy_o is low.

module color_gradient_evaluator_core #(
  parameter int unsigned MAX_STOPS   = cge_pkg::MAX_STOPS_DEF,
  parameter int unsigned RAMP_LENGTH = cge_pkg::RAMP_LENGTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  cge_pkg::cge_item_t              item_i,
  output logic                            busy_o,
  output logic                            result_strobe_o,
  output cge_pkg::cge_result_t            result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cge_pkg::STOP_CNT_W-1:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_STOPS);

  cge_pkg::cge_cmd_t     cmd;
  cge_pkg::cge_status_t  status;
  logic [AW-1:0]         rd_addr;

  assign cfg_ready_o = 1'b1;

  // sequencer
  cge_ctrl #(
    .MAX_STOPS (MAX_STOPS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .operation_i     (item_i.operation),
    .status_i        (status),
    .cmd_o           (cmd),
    .rd_addr_o       (rd_addr),
    .busy_o          (busy_o),
    .result_strobe_o (result_strobe_o)
  );

  // table, search and blend
  cge_datapath #(
    .MAX_STOPS   (MAX_STOPS),
    .RAMP_LENGTH (RAMP_LENGTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_wr_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .rd_addr_i  (rd_addr),
    .status_o   (status),
    .result_o   (result_o)
  );

endmodule

FILE: rtl/cge_ctrl.sv
`timescale 1ns / 1ps

module cge_ctrl #(
  parameter int unsigned MAX_STOPS = cge_pkg::MAX_STOPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  cge_pkg::cge_op_e              operation_i,
  input  cge_pkg::cge_status_t          status_i,
  output cge_pkg::cge_cmd_t             cmd_o,
  output logic [$clog2(MAX_STOPS)-1:0]  rd_addr_o,
  output logic                          busy_o,
  output logic                          result_strobe_o
);

  localparam int unsigned AW = $clog2(MAX_STOPS);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_CALC  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } cge_state_e;

  cge_state_e                      state_q, state_d;
  logic [AW-1:0]                   scan_q, scan_d;
  logic [cge_pkg::DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic                            accept;

  assign accept = start_i && (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d          = state_q;
    scan_d           = scan_q;
    div_cnt_d        = div_cnt_q;
    cmd_o            = '0;
    cmd_o.wr_stop    = accept && (operation_i == cge_pkg::OP_WRITE);
    cmd_o.capture    = accept && (operation_i == cge_pkg::OP_EVAL);
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        scan_d = '0;
        if (status_i.skip) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end else begin
          scan_d = scan_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        div_cnt_d  = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + cge_pkg::DIV_CNT_W'(1);
        if (div_cnt_q == cge_pkg::DIV_CNT_W'(cge_pkg::DIV_STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      scan_q    <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  assign rd_addr_o       = scan_q;
  assign busy_o          = (state_q != ST_IDLE);
  assign result_strobe_o = (state_q == ST_DONE);

endmodule

FILE: rtl/cge_datapath.sv
`timescale 1ns / 1ps

module cge_datapath #(
  parameter int unsigned MAX_STOPS   = cge_pkg::MAX_STOPS_DEF,
  parameter int unsigned RAMP_LENGTH = cge_pkg::RAMP_LENGTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cge_pkg::cge_item_t                    item_i,
  input  logic                                  cfg_wr_i,
  input  logic [cge_pkg::STOP_CNT_W-1:0]        cfg_data_i,
  input  cge_pkg::cge_cmd_t                     cmd_i,
  input  logic [$clog2(MAX_STOPS)-1:0]          rd_addr_i,
  output cge_pkg::cge_status_t                  status_o,
  output cge_pkg::cge_result_t                  result_o
);

  localparam int unsigned AW = $clog2(MAX_STOPS);
  localparam int unsigned NW = $clog2(MAX_STOPS + 1);

  // stop table storage
  cge_pkg::cge_stop_t  stop_mem [MAX_STOPS];
  logic [MAX_STOPS-1:0] stop_vld_q;

  logic [cge_pkg::STOP_CNT_W-1:0]  stop_count_q;
  logic [cge_pkg::SAMPLE_W-1:0]    sample_q;
  logic [NW-1:0]                   n_q;
  logic                            in_range_q;

  cge_pkg::cge_stop_t  rd_data_q, cur_stop, prev_q, seg_lo_q, seg_hi_q, wr_stop;
  logic [AW-1:0]       rd_idx_q;
  logic                rd_vld_q, rd_bit_q, rd_is_one_q;
  logic                found_q;
  logic                wr_ok;
  logic [AW-1:0]       wr_addr;
  logic [cge_pkg::POS_W-1:0] p_pos;
  logic                hit;

  logic [cge_pkg::POS_W-1:0] seg_w, seg_a, seg_b;
  logic [cge_pkg::NUM_W-1:0] num [cge_pkg::NUM_CH];
  logic [cge_pkg::NUM_W-1:0] rem_q [cge_pkg::NUM_CH];
  logic [cge_pkg::NUM_W-1:0] dvs_q;
  logic [cge_pkg::CH_W-1:0]  quo_q [cge_pkg::NUM_CH];

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= cge_pkg::STOP_CNT_RST;
    end else if (cfg_wr_i) begin
      stop_count_q <= cfg_data_i;
    end
  end

  // stop write decode
  assign wr_ok   = cmd_i.wr_stop && (32'(item_i.stop_index) < MAX_STOPS);
  assign wr_addr = AW'(item_i.stop_index);

  always_comb begin
    wr_stop.pos                = item_i.stop_position;
    wr_stop.ch[cge_pkg::CH_RED]   = item_i.stop_red;
    wr_stop.ch[cge_pkg::CH_GREEN] = item_i.stop_green;
    wr_stop.ch[cge_pkg::CH_BLUE]  = item_i.stop_blue;
    wr_stop.ch[cge_pkg::CH_ALPHA] = item_i.stop_alpha;
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      stop_mem[wr_addr] <= wr_stop;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= stop_mem[rd_addr_i];
    end
  end

  // written flags, entries never written read as their reset stop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_vld_q  <= '0;
      rd_vld_q    <= 1'b0;
      rd_bit_q    <= 1'b0;
      rd_is_one_q <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      if (wr_ok) begin
        stop_vld_q[wr_addr] <= 1'b1;
      end
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.rd_en) begin
        rd_bit_q    <= stop_vld_q[rd_addr_i];
        rd_is_one_q <= (rd_addr_i == AW'(1));
        rd_idx_q    <= rd_addr_i;
      end
    end
  end

  always_comb begin
    if (rd_bit_q) begin
      cur_stop = rd_data_q;
    end else if (rd_is_one_q) begin
      cur_stop = cge_pkg::STOP_WHITE;
    end else begin
      cur_stop = cge_pkg::STOP_ZERO;
    end
  end

  // sample capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q   <= item_i.sample_position;
      in_range_q <= (32'(item_i.sample_position) < RAMP_LENGTH);
      if (32'(stop_count_q) > MAX_STOPS) begin
        n_q <= NW'(MAX_STOPS);
      end else begin
        n_q <= NW'(stop_count_q);
      end
    end
  end

  assign status_o.skip      = (n_q < NW'(2)) || !in_range_q;
  assign status_o.scan_last = (rd_addr_i == AW'(n_q - NW'(1)));

  // segment search, the last matching segment wins
  assign p_pos = cge_pkg::POS_W'(sample_q);
  assign hit   = (prev_q.pos <= p_pos) && (p_pos < cur_stop.pos);

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prev_q <= cur_stop;
      if ((rd_idx_q != '0) && hit) begin
        seg_lo_q <= prev_q;
        seg_hi_q <= cur_stop;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.capture) begin
      found_q <= 1'b0;
    end else if (rd_vld_q && (rd_idx_q != '0) && hit) begin
      found_q <= 1'b1;
    end
  end

  // blend numerators, one lane per channel
  assign seg_w = seg_hi_q.pos - seg_lo_q.pos;
  assign seg_a = seg_hi_q.pos - p_pos;
  assign seg_b = p_pos - seg_lo_q.pos;

  always_comb begin
    for (int k = 0; k < cge_pkg::NUM_CH; k++) begin
      num[k] = cge_pkg::NUM_W'(seg_lo_q.ch[k]) * cge_pkg::NUM_W'(seg_a)
             + cge_pkg::NUM_W'(seg_hi_q.ch[k]) * cge_pkg::NUM_W'(seg_b)
             + cge_pkg::NUM_W'(seg_w >> 1);
    end
  end

  // restoring divide, one quotient bit per step, msb first
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      dvs_q <= cge_pkg::NUM_W'(seg_w) << (cge_pkg::DIV_STEPS - 1);
      for (int k = 0; k < cge_pkg::NUM_CH; k++) begin
        rem_q[k] <= num[k];
      end
    end else if (cmd_i.div_step) begin
      dvs_q <= dvs_q >> 1;
      for (int k = 0; k < cge_pkg::NUM_CH; k++) begin
        if (rem_q[k] >= dvs_q) begin
          rem_q[k] <= rem_q[k] - dvs_q;
          quo_q[k] <= {quo_q[k][cge_pkg::CH_W-2:0], 1'b1};
        end else begin
          quo_q[k] <= {quo_q[k][cge_pkg::CH_W-2:0], 1'b0};
        end
      end
    end
  end

  // result, zeros when no segment holds the sample
  always_comb begin
    result_o = '0;
    if (found_q) begin
      result_o.out_red   = quo_q[cge_pkg::CH_RED];
      result_o.out_green = quo_q[cge_pkg::CH_GREEN];
      result_o.out_blue  = quo_q[cge_pkg::CH_BLUE];
      result_o.out_alpha = quo_q[cge_pkg::CH_ALPHA];
      result_o.covered   = 1'b1;
    end
  end

endmodule

FILE: rtl/cge_checker.sv
`timescale 1ns / 1ps

module cge_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  cge_pkg::cge_item_t    item_i,
  input  logic                  busy_o,
  input  logic                  result_strobe_o,
  input  cge_pkg::cge_result_t  result_o
);

  // a result only closes a busy evaluate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> busy_o)
    else $error("result strobe outside a busy period");

  // the block frees up right after a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |=> !busy_o)
    else $error("still busy after result");

  // an accepted evaluate holds the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (item_i.operation == cge_pkg::OP_EVAL)) |=> busy_o)
    else $error("evaluate transaction did not raise busy");

  // a stop write gives no result and does not occupy the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (item_i.operation == cge_pkg::OP_WRITE))
      |=> (!result_strobe_o && !busy_o))
    else $error("stop write produced activity");

  // uncovered samples come back black and transparent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !result_o.covered) |->
      ((result_o.out_red == '0) && (result_o.out_green == '0) &&
       (result_o.out_blue == '0) && (result_o.out_alpha == '0)))
    else $error("uncovered result with nonzero channels");

endmodule

bind color_gradient_evaluator_core cge_checker u_cge_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .item_i          (item_i),
  .busy_o          (busy_o),
  .result_strobe_o (result_strobe_o),
  .result_o        (result_o)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import cge_pkg::*;

  localparam int unsigned STOPS        = MAX_STOPS_DEF;
  localparam int unsigned RAMP         = RAMP_LENGTH_DEF;
  localparam int unsigned CYCLE_CAP    = 400000;
  localparam int unsigned RANDOM_ITEMS = 640;
  localparam int unsigned SHOW_CAP     = 40;

  // expected colors, worked out from a private copy of the stop table
  class color_board;
    logic [POS_W-1:0]      stop_pos [STOPS];
    logic [CH_W-1:0]       stop_ch  [STOPS][NUM_CH];
    logic [STOP_CNT_W-1:0] stop_count;
    cge_result_t           expected_colors [$];
    int unsigned           errors, writes, evals, hits;

    function new();
      for (int i = 0; i < STOPS; i++) begin
        stop_pos[i] = '0;
        for (int k = 0; k < NUM_CH; k++) stop_ch[i][k] = (i == 1) ? '1 : '0;
      end
      stop_pos[1] = POS_W'(256);
      stop_count  = STOP_CNT_RST;
      errors = 0;
      writes = 0;
      evals  = 0;
      hits   = 0;
    endfunction

    // interpolated color at one sample position
    function cge_result_t shade_at(logic [SAMPLE_W-1:0] p);
      cge_result_t     res;
      int              seg;
      int unsigned     n, lo, hi, w, num;
      logic [CH_W-1:0] c [NUM_CH];
      res = '0;
      seg = -1;
      n   = (stop_count > STOPS) ? STOPS : stop_count;
      // last matching segment wins when stops are out of order
      if (p < RAMP)
        for (int i = 0; i + 1 < n; i++)
          if (stop_pos[i] <= p && p < stop_pos[i+1]) seg = i;
      if (seg >= 0) begin
        lo = stop_pos[seg];
        hi = stop_pos[seg+1];
        w  = hi - lo;
        for (int k = 0; k < NUM_CH; k++) begin
          num  = stop_ch[seg][k] * (hi - p) + stop_ch[seg+1][k] * (p - lo) + (w >> 1);
          c[k] = CH_W'(num / w);
        end
        res.out_red   = c[CH_RED];
        res.out_green = c[CH_GREEN];
        res.out_blue  = c[CH_BLUE];
        res.out_alpha = c[CH_ALPHA];
        res.covered   = 1'b1;
      end
      return res;
    endfunction

    // an accepted input transaction
    function void note_item(cge_item_t it);
      if (it.operation == OP_WRITE) begin
        if (it.stop_index < STOPS) begin
          stop_pos[it.stop_index]           = it.stop_position;
          stop_ch[it.stop_index][CH_RED]    = it.stop_red;
          stop_ch[it.stop_index][CH_GREEN]  = it.stop_green;
          stop_ch[it.stop_index][CH_BLUE]   = it.stop_blue;
          stop_ch[it.stop_index][CH_ALPHA]  = it.stop_alpha;
        end
        writes++;
      end else begin
        expected_colors = {expected_colors, shade_at(it.sample_position)};
        evals++;
      end
    endfunction

    // a result transaction against the oldest expected color
    function void check_result(cge_result_t got);
      cge_result_t     want;
      logic [CH_W-1:0] w_f [5];
      logic [CH_W-1:0] g_f [5];
      string           names [5] = '{"out_red", "out_green", "out_blue", "out_alpha",
                                     "covered"};
      if (expected_colors.size() == 0) begin
        errors++;
        if (errors <= SHOW_CAP)
          $display("%0t: result with none expected, expected nothing, got %h", $time, got);
        return;
      end
      want = expected_colors.pop_front();
      if (want.covered) hits++;
      w_f = '{want.out_red, want.out_green, want.out_blue, want.out_alpha,
              CH_W'(want.covered)};
      g_f = '{got.out_red, got.out_green, got.out_blue, got.out_alpha,
              CH_W'(got.covered)};
      for (int k = 0; k < 5; k++)
        if (w_f[k] !== g_f[k]) begin
          errors++;
          if (errors <= SHOW_CAP)
            $display("%0t: %s expected %0d got %0d", $time, names[k], w_f[k], g_f[k]);
        end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  cge_item_t             item_i      = '0;
  logic                  busy_o;
  logic                  result_strobe_o;
  cge_result_t           result_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [STOP_CNT_W-1:0] cfg_data_i  = '0;

  color_board  board = new();
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned cfg_writes = 0;
  bit          steady = 1'b0;

  color_gradient_evaluator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .item_i          (item_i),
    .busy_o          (busy_o),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) board.check_result(result_o);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("FAIL color_gradient_evaluator_core");
      $finish;
    end
  end

  // drive one transaction, with random idle cycles ahead of it unless steady is set
  task automatic send_item(cge_item_t it);
    if (!steady)
      while ($urandom_range(99) < 34) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    board.note_item(it);
    sent++;
  endtask

  function automatic cge_item_t rand_item(cge_op_e op);
    cge_item_t it;
    it.operation       = op;
    it.stop_index      = IDX_W'($urandom);
    it.stop_position   = POS_W'($urandom);
    it.stop_red        = CH_W'($urandom);
    it.stop_green      = CH_W'($urandom);
    it.stop_blue       = CH_W'($urandom);
    it.stop_alpha      = CH_W'($urandom);
    it.sample_position = SAMPLE_W'($urandom);
    return it;
  endfunction

  task automatic write_stop(int unsigned idx, int unsigned pos, int unsigned r,
                            int unsigned g, int unsigned b, int unsigned a);
    cge_item_t it;
    it               = rand_item(OP_WRITE);
    it.stop_index    = IDX_W'(idx);
    it.stop_position = POS_W'(pos);
    it.stop_red      = CH_W'(r);
    it.stop_green    = CH_W'(g);
    it.stop_blue     = CH_W'(b);
    it.stop_alpha    = CH_W'(a);
    send_item(it);
  endtask

  task automatic eval_at(int unsigned p);
    cge_item_t it;
    it                 = rand_item(OP_EVAL);
    it.sample_position = SAMPLE_W'(p);
    send_item(it);
  endtask

  // hold off until every expected color is back, then let the block settle
  task automatic drain(int unsigned margin);
    start_i <= 1'b0;
    while (board.expected_colors.size() != 0) @(posedge clk_i);
    repeat (margin) @(posedge clk_i);
  endtask

  task automatic load_stop_count(int unsigned v);
    drain(4);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= STOP_CNT_W'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.stop_count = STOP_CNT_W'(v);
    cfg_writes++;
  endtask

  // ascending ramp of m stops, then samples across it
  task automatic lay_ramp(int unsigned m);
    int unsigned spot [STOPS];
    int unsigned room, step;
    spot[0] = ($urandom_range(3) == 0) ? $urandom_range(40) : 0;
    for (int k = 1; k < m; k++) begin
      room    = RAMP - spot[k-1];
      step    = $urandom_range(2 * room / (m - k));
      spot[k] = (spot[k-1] + step > RAMP) ? RAMP : spot[k-1] + step;
    end
    if ($urandom_range(3) != 0) spot[m-1] = RAMP;
    for (int k = 0; k < m; k++)
      write_stop(k, spot[k], $urandom_range(255), $urandom_range(255),
                 $urandom_range(255), $urandom_range(255));
    if ($urandom_range(9) == 0) drain(0);
    repeat ($urandom_range(12, 6)) begin
      if ($urandom_range(3) == 0) eval_at(spot[$urandom_range(m - 1)]);
      else eval_at($urandom_range(255));
    end
  endtask

  // stray writes anywhere, any position, then a few samples
  task automatic scramble();
    repeat ($urandom_range(3, 1)) send_item(rand_item(OP_WRITE));
    repeat ($urandom_range(4, 2)) eval_at($urandom_range(255));
  endtask

  // stimulus
  initial begin
    int unsigned phase_counts [10] = '{16, 0, 31, 5, 1, 17, 9, 3, 12, 2};
    int unsigned budget, span;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset table: black at 0, white at 256
    eval_at(0);
    eval_at(255);
    eval_at(128);
    // two-wide segment, tie rounds up, right end not held
    write_stop(1, 2, 1, 1, 1, 1);
    eval_at(1);
    eval_at(2);
    // widest position, nothing covered
    write_stop(0, 511, 255, 255, 255, 255);
    eval_at(0);
    write_stop(0, 0, 255, 0, 255, 0);
    write_stop(1, 256, 0, 255, 0, 255);
    eval_at(100);
    // out-of-order stops, highest matching segment wins
    load_stop_count(4);
    write_stop(2, 10, 12, 200, 77, 3);
    write_stop(3, 200, 250, 1, 128, 90);
    eval_at(50);
    eval_at(5);
    eval_at(255);
    // count of zero, of one, and beyond the table size
    write_stop(15, 256, 255, 255, 255, 255);
    load_stop_count(0);
    eval_at(7);
    load_stop_count(31);
    eval_at(255);
    load_stop_count(1);
    eval_at(3);
    load_stop_count(16);
    eval_at(128);

    // random phases, each under its own stop_count
    foreach (phase_counts[ph]) begin
      load_stop_count(phase_counts[ph]);
      steady = (ph == 3);
      span   = (phase_counts[ph] > STOPS) ? STOPS : phase_counts[ph];
      budget = sent + RANDOM_ITEMS / $size(phase_counts);
      while (sent < budget) begin
        if (span < 2) lay_ramp($urandom_range(6, 2));
        else if ($urandom_range(4) != 0) lay_ramp(span);
        else scramble();
      end
    end
    steady = 1'b0;

    drain(40);
    $display("ran %0d stop writes and %0d samples (%0d inside a segment)",
             board.writes, board.evals, board.hits);
    $display("over %0d stop_count settings from 0 to 31", cfg_writes);
    if (board.errors == 0) begin
      $display("PASS color_gradient_evaluator_core");
    end else begin
      $display("FAIL color_gradient_evaluator_core");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cge_pkg.sv
rtl/cge_ctrl.sv
rtl/cge_datapath.sv
rtl/color_gradient_evaluator_core.sv
rtl/cge_checker.sv
verif/tb.sv
